>>> rtl/vfp_pkg.sv
// Shared types and constants for the vision frame parser.
// No dependencies; compiled before every other file.
`default_nettype none

package vfp_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned POS_W = $clog2(FRAME_BYTES);

  localparam logic [7:0] HEAD_FIRST  = 8'hAA;
  localparam logic [7:0] HEAD_SECOND = 8'h55;
  localparam logic [7:0] DATA_ALL_ONES = 8'hFF;

  // Byte positions within a frame
  localparam logic [POS_W-1:0] POS_HEAD0  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HEAD1  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_STATUS = POS_W'(2);
  localparam logic [POS_W-1:0] POS_X_LO   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_X_HI   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_Y_LO   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_Y_HI   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_CHECK  = POS_W'(FRAME_BYTES - 1);

  // Configuration register indexes
  localparam logic CFG_VALID_CODE = 1'b0;
  localparam logic CFG_LOST_CODE  = 1'b1;

  typedef struct packed {
    logic [7:0]         frame_status;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
  } frame_result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_slot_t;

endpackage

`default_nettype wire

>>> rtl/vfp_channels.sv
// Valid/ready channel interfaces for the vision frame parser.
// Depends on nothing; the payload widths follow the frame layout.
`default_nettype none

interface vfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface vfp_frame_if;
  logic               valid;
  logic               ready;
  logic [7:0]         frame_status;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;

  modport source (output valid, output frame_status, output x_coord, output y_coord,
                  input ready);
  modport sink   (input valid, input frame_status, input x_coord, input y_coord,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/vfp_byte_stage.sv
// Input register for received bytes.
// Depends on vfp_pkg and vfp_byte_if.
`default_nettype none

module vfp_byte_stage
  import vfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  vfp_byte_if.sink   rx,
  input  wire logic  advance,
  output byte_slot_t slot
);

  logic       held_valid;
  logic [7:0] held_byte;

  assign rx.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx.ready) begin
      held_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      held_byte <= rx.rx_byte;
    end
  end

  assign slot.valid = held_valid;
  assign slot.data  = held_byte;

endmodule

`default_nettype wire

>>> rtl/vfp_frame_core.sv
// Frame hunt, running checksum and acceptance check, plus the status code registers.
// Depends on vfp_pkg.
`default_nettype none

module vfp_frame_core
  import vfp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [7:0]    cfg_data,
  input  wire byte_slot_t    slot,
  input  wire logic          advance,
  output logic               hit,
  output frame_result_t      result
);

  logic [7:0]       valid_code;
  logic [7:0]       lost_code;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [7:0]       sum;
  logic [7:0]       sum_next;
  logic [7:0]       status;
  logic [7:0]       x_lo, x_hi, y_lo, y_hi;
  logic             step;
  logic             restart;
  logic             lost_ok;

  assign step    = slot.valid && advance;
  assign restart = (pos == POS_HEAD0) || (pos == POS_HEAD1 && slot.data != HEAD_SECOND);

  always_comb begin
    if (restart) begin
      pos_next = (slot.data == HEAD_FIRST) ? POS_HEAD1 : POS_HEAD0;
      sum_next = slot.data;
    end else if (pos == POS_CHECK) begin
      pos_next = POS_HEAD0;
      sum_next = sum;
    end else begin
      pos_next = pos + POS_W'(1);
      sum_next = sum + slot.data;
    end
  end

  assign lost_ok = (status == lost_code) && (x_lo == DATA_ALL_ONES) &&
                   (x_hi == DATA_ALL_ONES) && (y_lo == DATA_ALL_ONES) &&
                   (y_hi == DATA_ALL_ONES);

  assign hit = slot.valid && (pos == POS_CHECK) && (sum == slot.data) &&
               ((status == valid_code) || lost_ok);

  assign result.frame_status = status;
  assign result.x_coord      = $signed({x_hi, x_lo});
  assign result.y_coord      = $signed({y_hi, y_lo});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_code <= 8'd1;
      lost_code  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VALID_CODE: valid_code <= cfg_data;
        CFG_LOST_CODE:  lost_code  <= cfg_data;
        default:        valid_code <= valid_code;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_HEAD0;
    end else if (step) begin
      pos <= pos_next;
    end
  end

  // Frame bytes; no reset needed, each is written before it is read
  always_ff @(posedge clk) begin
    if (step) begin
      sum <= sum_next;
      if (!restart) begin
        case (pos)
          POS_STATUS: status <= slot.data;
          POS_X_LO:   x_lo   <= slot.data;
          POS_X_HI:   x_hi   <= slot.data;
          POS_Y_LO:   y_lo   <= slot.data;
          POS_Y_HI:   y_hi   <= slot.data;
          default:    status <= status;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/vfp_out_reg.sv
// Output register for decoded frames.
// Depends on vfp_pkg and vfp_frame_if.
`default_nettype none

module vfp_out_reg
  import vfp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          hit,
  input  wire frame_result_t result,
  output logic               advance,
  vfp_frame_if.source        res
);

  logic          held_valid;
  frame_result_t held;

  // Take a new byte whenever the register is empty or being drained
  assign advance = !held_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (advance) begin
      held_valid <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      held <= result;
    end
  end

  assign res.valid        = held_valid;
  assign res.frame_status = held.frame_status;
  assign res.x_coord      = held.x_coord;
  assign res.y_coord      = held.y_coord;

endmodule

`default_nettype wire

>>> rtl/vision_frame_parser_top.sv
// Top level of the vision frame parser.
// Depends on vfp_pkg, vfp_channels, vfp_byte_stage, vfp_frame_core, vfp_out_reg.
//
// Usage:
//   byte_in carries received bytes, one per request. frame_out carries one
//   request per accepted 8-byte frame (AA 55 status xl xh yl yh checksum):
//   the status byte and the signed little-endian x and y.
//   cfg_we/cfg_index/cfg_data write the valid status code (index 0, reset 1)
//   and the lost status code (index 1, reset 0); write only while idle.
// Throughput: one byte per cycle while frame_out is not stalled, set by the
//   position counter and running checksum update.
// Output path: a frame's checksum byte is held in the input register once accepted;
//   the frame is then loaded into the output register that drives frame_out.
// Reset: synchronous, active high; clears the hunt to the first header byte
//   and empties both registers. Frame bytes themselves are not cleared.
// Stall: while frame_out holds a frame and ready is low, the parser holds;
//   byte_in takes one more byte only if its input register is empty.
`default_nettype none

module vision_frame_parser_top
  import vfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  vfp_byte_if.sink        byte_in,
  vfp_frame_if.source     frame_out,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  byte_slot_t    slot;
  frame_result_t result;
  logic          hit;
  logic          advance;

  vfp_byte_stage u_byte_stage (
    .clk     (clk),
    .rst     (rst),
    .rx      (byte_in),
    .advance (advance),
    .slot    (slot)
  );

  vfp_frame_core u_frame_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .slot      (slot),
    .advance   (advance),
    .hit       (hit),
    .result    (result)
  );

  vfp_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .hit     (hit),
    .result  (result),
    .advance (advance),
    .res     (frame_out)
  );

endmodule

`default_nettype wire
